[sv/assert_macros.svh]
// Assertion macros shared by the prefix table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define LPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define LPT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[sv/lpt_pkg.sv]
// Shared types, codes and constants of the IPv4 prefix table.
package lpt_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int LENGTH_LEVELS     = 33;
	localparam int ADDR_W            = 32;
	localparam int LEN_W             = 6;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LENGTH_LEVELS - 1);

	// Request types
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_SEARCH = 2'd2;
	localparam logic [1:0] REQ_NOP    = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_MISS = 2'd2;

	// One table slot as held in the memory
	typedef struct packed {
		logic             valid;
		logic [LEN_W-1:0] len;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	// Compare unit verdict on one slot
	typedef struct packed {
		logic free;
		logic exact;
		logic covers;
		logic longer;
	} match_t;

endpackage

[sv/lpt_if.sv]
// Request and result channel interfaces of the IPv4 prefix table.
interface lpt_req_if;
	import lpt_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [ADDR_W-1:0] req_addr;
	logic [LEN_W-1:0]  prefix_len;

	modport source (output valid, output req_type, output req_addr, output prefix_len,
		input ready);
	modport sink (input valid, input req_type, input req_addr, input prefix_len,
		output ready);
endinterface

interface lpt_rsp_if;
	import lpt_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic             hit;
	logic [LEN_W-1:0] match_len;

	modport source (output valid, output status, output hit, output match_len,
		input ready);
	modport sink (input valid, input status, input hit, input match_len,
		output ready);
endinterface

[sv/lpt_mem.sv]
// Slot memory: one write port, one registered read port.
module lpt_mem #(
	parameter int DEPTH = lpt_pkg::TABLE_ENTRIES_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_idx,
	input  lpt_pkg::entry_t   wr_data,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_idx,
	output lpt_pkg::entry_t   rd_data
);
	import lpt_pkg::*;

	entry_t mem [DEPTH];

	// Write one slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// Read one slot into the output register
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

[sv/lpt_match.sv]
// Shared compare unit: judges one slot against the current request.
module lpt_match (
	input  lpt_pkg::entry_t              ent,
	input  logic [lpt_pkg::ADDR_W-1:0]   key_addr,
	input  logic [lpt_pkg::LEN_W-1:0]    key_len,
	input  logic                         found,
	input  logic [lpt_pkg::LEN_W-1:0]    best_len,
	output lpt_pkg::match_t              res
);
	import lpt_pkg::*;

	logic [ADDR_W-1:0] mask;

	// Keep the top ent.len bits; a length of zero masks everything out
	assign mask = ~({ADDR_W{1'b1}} >> ent.len);

	always_comb begin
		res.free   = !ent.valid;
		res.exact  = ent.valid && (ent.addr == key_addr) && (ent.len == key_len);
		res.covers = ent.valid && (((ent.addr ^ key_addr) & mask) == '0);
		res.longer = !found || (ent.len > best_len);
	end

endmodule

[sv/ipv4_longest_prefix_table.sv]
// Top level of the IPv4 prefix table with longest-prefix search.
//
// Holds up to TABLE_ENTRIES prefixes in one single-port-read memory and serves one request at
// a time: insert into the lowest free slot, delete the lowest slot with equal address and
// length, or search for the longest stored prefix covering an address. One compare unit walks
// the slots one per cycle: a search reads every slot before its result is valid; an insert
// or delete stops at the slot it acts on, or reads every slot when it finds none. Request type
// three is answered without a scan. A result that cannot enter the output register because the
// previous one is still waiting holds the sequencer in its done state until it can. The next
// request is taken at the earliest in the cycle after the result enters the output register.
// After reset a clearing pass invalidates every slot, one slot after another; no request is
// taken meanwhile. The result register lets the next request be taken while a result waits.
`include "assert_macros.svh"

module ipv4_longest_prefix_table #(
	parameter int TABLE_ENTRIES = lpt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lpt_req_if.sink     req,
	lpt_rsp_if.source   rsp
);
	import lpt_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// Sequencer states
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  idx_q;
	logic              issue_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	logic [1:0]        type_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic              found_q;
	logic [LEN_W-1:0]  best_q;

	logic [1:0]        res_status_q;
	logic              res_hit_q;
	logic [LEN_W-1:0]  res_len_q;

	logic              out_vld_q;
	logic [1:0]        out_status_q;
	logic              out_hit_q;
	logic [LEN_W-1:0]  out_len_q;

	logic              req_acc;
	logic [LEN_W-1:0]  req_len_sat;
	logic              rd_en;
	entry_t            rd_data;
	logic              mem_wr_en;
	logic [IDX_W-1:0]  mem_wr_idx;
	entry_t            mem_wr_data;
	match_t            m;
	logic              chk;
	logic              ins_hit;
	logic              del_hit;
	logic              srch_upd;
	logic              found_nx;
	logic [LEN_W-1:0]  best_nx;
	logic              finish;
	logic              out_load;
	logic [1:0]        fin_status;
	logic              fin_hit;
	logic [LEN_W-1:0]  fin_len;

	// Handshake
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign req_len_sat = (req.prefix_len > MAX_LEN) ? MAX_LEN : req.prefix_len;

	lpt_mem #(
		.DEPTH (TABLE_ENTRIES),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_idx  (mem_wr_idx),
		.wr_data (mem_wr_data),
		.rd_en   (rd_en),
		.rd_idx  (idx_q),
		.rd_data (rd_data)
	);

	lpt_match u_match (
		.ent      (rd_data),
		.key_addr (addr_q),
		.key_len  (len_q),
		.found    (found_q),
		.best_len (best_q),
		.res      (m)
	);

	// Judge the slot read in the previous cycle
	assign chk      = (state_q == ST_SCAN) && rd_vld_s1;
	assign ins_hit  = chk && (type_q == REQ_INSERT) && m.free;
	assign del_hit  = chk && (type_q == REQ_DELETE) && m.exact;
	assign srch_upd = chk && (type_q == REQ_SEARCH) && m.covers && m.longer;
	assign found_nx = found_q || (chk && (type_q == REQ_SEARCH) && m.covers);
	assign best_nx  = srch_upd ? rd_data.len : best_q;
	assign finish   = ins_hit || del_hit || (chk && (rd_idx_s1 == LAST_IDX));
	assign rd_en    = (state_q == ST_SCAN) && issue_q && !finish;

	// Result of the request that finishes now
	always_comb begin
		fin_status = STAT_DONE;
		fin_hit    = 1'b0;
		fin_len    = '0;
		case (type_q)
			REQ_INSERT: begin
				fin_status = ins_hit ? STAT_DONE : STAT_FULL;
			end
			REQ_DELETE: begin
				fin_status = del_hit ? STAT_DONE : STAT_MISS;
				fin_hit    = del_hit;
			end
			REQ_SEARCH: begin
				fin_status = found_nx ? STAT_DONE : STAT_MISS;
				fin_hit    = found_nx;
				fin_len    = found_nx ? best_nx : '0;
			end
			default: begin
				fin_status = STAT_DONE;
			end
		endcase
	end

	// Select the memory write: clearing sweep, insert or delete
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_idx  = rd_idx_s1;
		mem_wr_data = rd_data;
		if (state_q == ST_CLEAR) begin
			mem_wr_en   = 1'b1;
			mem_wr_idx  = idx_q;
			mem_wr_data = '0;
		end else if (ins_hit) begin
			mem_wr_en        = 1'b1;
			mem_wr_data.valid = 1'b1;
			mem_wr_data.len   = len_q;
			mem_wr_data.addr  = addr_q;
		end else if (del_hit) begin
			mem_wr_en         = 1'b1;
			mem_wr_data.valid = 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			idx_q     <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			case (state_q)
				ST_CLEAR: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						if (req.req_type == REQ_NOP) begin
							state_q <= ST_DONE;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					found_q <= found_nx;
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end
					end
					if (finish) begin
						issue_q <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the request fields and the running best length
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (req_acc) begin
			type_q <= req.req_type;
			addr_q <= req.req_addr;
			len_q  <= req_len_sat;
			best_q <= '0;
		end else if (state_q == ST_SCAN) begin
			best_q <= best_nx;
		end
	end

	// Capture the result when the request finishes, or on acceptance of request type three
	always_ff @(posedge clk) begin
		if (req_acc && (req.req_type == REQ_NOP)) begin
			res_status_q <= STAT_DONE;
			res_hit_q    <= 1'b0;
			res_len_q    <= '0;
		end else if (finish) begin
			res_status_q <= fin_status;
			res_hit_q    <= fin_hit;
			res_len_q    <= fin_len;
		end
	end

	// Output register: advance the result once the previous one is taken
	assign out_load = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_hit_q    <= res_hit_q;
			out_len_q    <= res_len_q;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.status    = out_status_q;
	assign rsp.hit       = out_hit_q;
	assign rsp.match_len = out_len_q;

	`LPT_ASSERT(a_acc_starts_work, req_acc |=> (state_q == ST_SCAN || state_q == ST_DONE), "accepted request did not start")
	`LPT_ASSERT(a_wr_when_busy, mem_wr_en |-> (state_q == ST_CLEAR || state_q == ST_SCAN), "slot write outside clear or scan")
	`LPT_ASSERT(a_hit_is_done, out_vld_q && out_hit_q |-> out_status_q == STAT_DONE, "hit reported with failing status")
	`LPT_ASSERT_NEVER(a_len_range, out_vld_q && (out_len_q > MAX_LEN), "match length above 32")

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the IPv4 longest-prefix table: directed and random requests.
`timescale 1ns / 100ps

import lpt_pkg::*;

typedef struct packed {
	logic [1:0]       status;
	logic             hit;
	logic [LEN_W-1:0] match_len;
} lookup_result_t;

// Build the mask that keeps the top plen bits of an address
function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] plen);
	if (plen == '0)
		return '0;
	return {ADDR_W{1'b1}} << (ADDR_W - plen);
endfunction

// Shadow prefix table and queue of awaited lookup results
class prefix_scoreboard;
	localparam int SLOTS = TABLE_ENTRIES_DEF;

	bit                slot_used [SLOTS];
	logic [ADDR_W-1:0] slot_pfx  [SLOTS];
	logic [LEN_W-1:0]  slot_plen [SLOTS];
	lookup_result_t    awaited_q [$];
	int                mismatches;

	function new();
		foreach (slot_used[i])
			slot_used[i] = 1'b0;
		mismatches = 0;
	endfunction

	// Apply an accepted request to the shadow table and queue its result
	function void note_request(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
		input logic [LEN_W-1:0] raw_len);
		logic [LEN_W-1:0] plen;
		lookup_result_t   res;
		logic [ADDR_W-1:0] m;
		bit                found;
		plen = (raw_len > MAX_LEN) ? MAX_LEN : raw_len;
		res = '{status: STAT_DONE, hit: 1'b0, match_len: '0};
		found = 1'b0;
		case (kind)
			REQ_INSERT: begin
				res.status = STAT_FULL;
				for (int i = 0; i < SLOTS; i++) begin
					if (!slot_used[i]) begin
						slot_used[i] = 1'b1;
						slot_pfx[i]  = addr;
						slot_plen[i] = plen;
						res.status   = STAT_DONE;
						break;
					end
				end
			end
			REQ_DELETE: begin
				res.status = STAT_MISS;
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_used[i] && slot_pfx[i] == addr && slot_plen[i] == plen) begin
						slot_used[i] = 1'b0;
						res.status   = STAT_DONE;
						res.hit      = 1'b1;
						break;
					end
				end
			end
			REQ_SEARCH: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_used[i]) begin
						m = prefix_mask(slot_plen[i]);
						if ((addr & m) == (slot_pfx[i] & m)) begin
							if (!found || slot_plen[i] > res.match_len)
								res.match_len = slot_plen[i];
							found = 1'b1;
						end
					end
				end
				res.hit = found;
				if (!found)
					res.status = STAT_MISS;
			end
			default: ;
		endcase
		awaited_q.push_back(res);
	endfunction

	// Compare a delivered result with the oldest awaited one
	function void check_result(input lookup_result_t got);
		lookup_result_t want;
		if (awaited_q.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: result with no request pending: status %0d hit %0d len %0d",
					$time, got.status, got.hit, got.match_len);
			mismatches++;
			return;
		end
		want = awaited_q.pop_front();
		if (got.status !== want.status || got.hit !== want.hit ||
			got.match_len !== want.match_len) begin
			if (mismatches < 10)
				$display("%0t: mismatch: expected status %0d hit %0d len %0d, got status %0d hit %0d len %0d",
					$time, want.status, want.hit, want.match_len,
					got.status, got.hit, got.match_len);
			mismatches++;
		end
	endfunction

	function int pending();
		return awaited_q.size();
	endfunction

	// Pick one stored prefix at random; return 0 when the table is empty
	function bit pick_stored(output logic [ADDR_W-1:0] addr, output logic [LEN_W-1:0] plen);
		int held [$];
		int k;
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i])
				held.push_back(i);
		if (held.size() == 0)
			return 1'b0;
		k = held[$urandom_range(0, held.size() - 1)];
		addr = slot_pfx[k];
		plen = slot_plen[k];
		return 1'b1;
	endfunction
endclass

module tb_top;
	localparam int TABLE_SIZE   = TABLE_ENTRIES_DEF;
	localparam int RANDOM_ITEMS = 1825;
	localparam int PHASE_ITEMS  = 450;
	localparam int LIMIT_CYCLES = 6000000;

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   burst_left;

	prefix_scoreboard table_sb;

	lpt_req_if req_ch ();
	lpt_rsp_if rsp_ch ();

	ipv4_longest_prefix_table #(.TABLE_ENTRIES(TABLE_SIZE)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Give up after a generous number of cycles
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Draw an address, often from a few clustered blocks so that prefixes overlap
	function automatic logic [ADDR_W-1:0] random_address();
		case ($urandom_range(0, 3))
			0:       return {16'hC0A8, 16'($urandom)};
			1:       return {8'h0A, 24'($urandom)};
			2:       return {12'hFFF, 20'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// Present one request, in bursts with idle gaps between them
	task automatic send_request(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
		input logic [LEN_W-1:0] plen);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 10);
		end
		req_ch.valid      = 1'b1;
		req_ch.req_type   = kind;
		req_ch.req_addr   = addr;
		req_ch.prefix_len = plen;
		do
			@(posedge clk);
		while (!req_ch.ready);
		table_sb.note_request(kind, addr, plen);
		burst_left--;
		@(negedge clk);
		if (burst_left == 0)
			req_ch.valid = 1'b0;
	endtask

	// Stall the result channel on a changing pattern
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			logic [7:0] stall_pattern;
			int         mode;
			mode = $urandom_range(0, 2);
			stall_pattern = $urandom;
			for (int c = 0; c < 128; c++) begin
				@(negedge clk);
				case (mode)
					0:       rsp_ch.ready = 1'b1;
					1:       rsp_ch.ready = $urandom_range(0, 1);
					default: rsp_ch.ready = stall_pattern[c % 8];
				endcase
			end
		end
	end

	// Check every delivered result
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			table_sb.check_result('{status: rsp_ch.status, hit: rsp_ch.hit,
				match_len: rsp_ch.match_len});
	end

	initial begin
		int unsigned       roll;
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] m;
		logic [LEN_W-1:0]  plen;
		bit                fill_phase;

		table_sb          = new();
		burst_left        = 0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_NOP;
		req_ch.req_addr   = '0;
		req_ch.prefix_len = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, default route, host route, nesting, saturation, duplicates
		send_request(REQ_SEARCH, 32'hC0A8_0101, 6'd0);
		send_request(REQ_DELETE, 32'h0000_0000, 6'd0);
		send_request(REQ_NOP,    32'hFFFF_FFFF, 6'd63);
		send_request(REQ_INSERT, 32'h0000_0000, 6'd0);
		send_request(REQ_SEARCH, 32'hFFFF_FFFF, 6'd0);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 6'd32);
		send_request(REQ_SEARCH, 32'hFFFF_FFFF, 6'd17);
		send_request(REQ_SEARCH, 32'hFFFF_FFFE, 6'd0);
		send_request(REQ_INSERT, 32'hC0A8_0000, 6'd16);
		send_request(REQ_INSERT, 32'hC0A8_0100, 6'd24);
		send_request(REQ_SEARCH, 32'hC0A8_01FF, 6'd0);
		send_request(REQ_SEARCH, 32'hC0A8_FF01, 6'd0);
		send_request(REQ_INSERT, 32'h0A00_00FF, 6'd8);
		send_request(REQ_SEARCH, 32'h0A12_3456, 6'd0);
		send_request(REQ_DELETE, 32'h0A00_0000, 6'd8);
		send_request(REQ_DELETE, 32'h0A00_00FF, 6'd8);
		send_request(REQ_INSERT, 32'h1234_5678, 6'd45);
		send_request(REQ_SEARCH, 32'h1234_5678, 6'd0);
		send_request(REQ_DELETE, 32'h1234_5678, 6'd63);
		send_request(REQ_INSERT, 32'hC0A8_0000, 6'd16);
		send_request(REQ_DELETE, 32'hC0A8_0000, 6'd16);
		send_request(REQ_SEARCH, 32'hC0A8_FF01, 6'd0);
		send_request(REQ_DELETE, 32'hC0A8_0000, 6'd16);
		send_request(REQ_SEARCH, 32'hC0A8_FF01, 6'd0);
		send_request(REQ_SEARCH, 32'h7FFF_FFFF, 6'd63);

		// Random: alternate fill phases, which reach a full table, and drain phases
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			fill_phase = ((i / PHASE_ITEMS) % 2) == 0;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				kind = REQ_NOP;
			else if (roll < (fill_phase ? 78 : 13))
				kind = REQ_INSERT;
			else if (roll < (fill_phase ? 86 : 70))
				kind = REQ_DELETE;
			else
				kind = REQ_SEARCH;

			case (kind)
				REQ_INSERT: begin
					// Mostly fresh prefixes, some duplicates of stored ones
					if ($urandom_range(0, 9) != 0 || !table_sb.pick_stored(addr, plen)) begin
						addr = random_address();
						plen = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(33, 63)) :
							6'($urandom_range(0, 32));
					end
				end
				REQ_DELETE: begin
					// Mostly stored prefixes; near misses differ in one address bit
					if ($urandom_range(0, 9) < 8 && table_sb.pick_stored(addr, plen)) begin
						if (plen == MAX_LEN && $urandom_range(0, 1))
							plen = 6'($urandom_range(33, 63));
						if ($urandom_range(0, 9) == 0)
							addr[0] = ~addr[0];
					end else begin
						addr = random_address();
						plen = 6'($urandom_range(0, 63));
					end
				end
				REQ_SEARCH: begin
					// Query inside a stored prefix, at its edge, or anywhere
					if ($urandom_range(0, 99) < 65 && table_sb.pick_stored(addr, plen)) begin
						m = prefix_mask(plen);
						addr = (addr & m) | (32'($urandom) & ~m);
						if ($urandom_range(0, 4) == 0 && plen != '0)
							addr = addr ^ (32'h1 << (ADDR_W - plen));
					end else begin
						addr = random_address();
					end
					plen = 6'($urandom_range(0, 63));
				end
				default: begin
					addr = $urandom;
					plen = 6'($urandom_range(0, 63));
				end
			endcase
			send_request(kind, addr, plen);
		end
		req_ch.valid = 1'b0;

		// Drain outstanding results, then watch for strays
		while (table_sb.pending() != 0)
			@(posedge clk);
		repeat (TABLE_SIZE + 8) @(posedge clk);
		if (table_sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
